>>> hdl/ahc_pkg.sv
// Shared constants, control codes and control/status structs for the adaptive Huffman codec.
// No dependencies; ahc_ctrl, ahc_dpath and the top level import this package.
`timescale 1ns / 1ps
package ahc_pkg;

    localparam int ALPHABET      = 256;
    localparam int WEIGHT_BITS   = 32;
    localparam int MAX_CODE_BITS = 64;
    localparam int SLOTS         = 2 * ALPHABET + 1;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int LC_W          = $clog2(ALPHABET + 1);
    localparam int LEN_W         = 7;
    localparam int CIDX_W        = $clog2(MAX_CODE_BITS);
    localparam int SYM_W         = 8;
    localparam int SYM_COUNT     = 256;

    // func codes
    localparam logic [1:0] FN_ENC = 2'd0;
    localparam logic [1:0] FN_DEC = 2'd1;
    localparam logic [1:0] FN_LIT = 2'd2;

    // status codes
    localparam logic [1:0] RES_CODE = 2'd0;
    localparam logic [1:0] RES_SYM  = 2'd1;
    localparam logic [1:0] RES_LIT  = 2'd2;
    localparam logic [1:0] RES_ERR  = 2'd3;

    // controller states, also the command to the datapath
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] S_CLR   = 5'd0;
    localparam logic [OP_W-1:0] S_IDLE  = 5'd1;
    localparam logic [OP_W-1:0] S_DISP  = 5'd2;
    localparam logic [OP_W-1:0] S_WA    = 5'd3;
    localparam logic [OP_W-1:0] S_WB    = 5'd4;
    localparam logic [OP_W-1:0] S_WC    = 5'd5;
    localparam logic [OP_W-1:0] S_ADD1  = 5'd6;
    localparam logic [OP_W-1:0] S_ADD2  = 5'd7;
    localparam logic [OP_W-1:0] S_ADD3  = 5'd8;
    localparam logic [OP_W-1:0] S_U0    = 5'd9;
    localparam logic [OP_W-1:0] S_U1    = 5'd10;
    localparam logic [OP_W-1:0] S_U2    = 5'd11;
    localparam logic [OP_W-1:0] S_U3    = 5'd12;
    localparam logic [OP_W-1:0] S_U4    = 5'd13;
    localparam logic [OP_W-1:0] S_U5    = 5'd14;
    localparam logic [OP_W-1:0] S_U6    = 5'd15;
    localparam logic [OP_W-1:0] S_U7    = 5'd16;
    localparam logic [OP_W-1:0] S_FX1   = 5'd17;
    localparam logic [OP_W-1:0] S_FX2   = 5'd18;
    localparam logic [OP_W-1:0] S_U9    = 5'd19;
    localparam logic [OP_W-1:0] S_U10   = 5'd20;
    localparam logic [OP_W-1:0] S_UROOT = 5'd21;
    localparam logic [OP_W-1:0] S_DREAD = 5'd22;
    localparam logic [OP_W-1:0] S_DCHK  = 5'd23;
    localparam logic [OP_W-1:0] S_FIN   = 5'd24;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic fire;
        logic d_res;
        logic d_none;
        logic d_walk;
        logic d_dread;
        logic d_add;
        logic wa_done;
        logic wa_err;
        logic fresh;
        logic n_zero;
        logic lm_zero;
        logic w_eq;
        logic lm_eq_n;
        logic fix_int;
        logic fix_b;
        logic dc_internal;
        logic dc_stop;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/ahc_if.sv
// Valid/ready channel interfaces for the codec request and response items.
// Depends on nothing.
`timescale 1ns / 1ps
interface ahc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] symbol;
    logic       bit_req;

    modport source (output valid, func, symbol, bit_req, input ready);
    modport sink (input valid, func, symbol, bit_req, output ready);
endinterface

interface ahc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] code_bits;
    logic [6:0]  code_len;
    logic        is_new;
    logic [7:0]  out_symbol;

    modport source (output valid, status, code_bits, code_len, is_new, out_symbol, input ready);
    modport sink (input valid, status, code_bits, code_len, is_new, out_symbol, output ready);
endinterface

>>> hdl/ahc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ahc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/ahc_ctrl.sv
// Sequencing state machine for the codec: walks, leader search, swaps and fixes.
// Depends on ahc_pkg.
`timescale 1ns / 1ps
module ahc_ctrl
    import ahc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output cmd_t  cmd
);

    logic [OP_W-1:0] state_reg;
    logic [OP_W-1:0] state_next;

    assign cmd.op = state_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:   if (stat.clr_done) state_next = S_IDLE;
            S_IDLE:  if (stat.fire) state_next = S_DISP;
            S_DISP:
            begin
                if (stat.d_res)        state_next = S_FIN;
                else if (stat.d_walk)  state_next = S_WA;
                else if (stat.d_dread) state_next = S_DREAD;
                else if (stat.d_add)   state_next = S_ADD1;
                else                   state_next = S_IDLE;
            end
            S_WA:
            begin
                if (stat.wa_done)     state_next = stat.fresh ? S_ADD1 : S_U0;
                else if (stat.wa_err) state_next = S_FIN;
                else                  state_next = S_WB;
            end
            S_WB:    state_next = S_WC;
            S_WC:    state_next = S_WA;
            S_ADD1:  state_next = S_ADD2;
            S_ADD2:  state_next = S_ADD3;
            S_ADD3:  state_next = S_U0;
            S_U0:    state_next = stat.n_zero ? S_UROOT : S_U1;
            S_U1:    state_next = S_U2;
            S_U2:    state_next = stat.lm_zero ? S_U4 : S_U3;
            S_U3:    state_next = stat.w_eq ? S_U2 : S_U4;
            S_U4:    state_next = S_U5;
            S_U5:    state_next = stat.lm_eq_n ? S_U9 : S_U6;
            S_U6:    state_next = S_U7;
            S_U7:    state_next = S_FX1;
            S_FX1:
            begin
                if (stat.fix_int)    state_next = S_FX2;
                else if (stat.fix_b) state_next = S_U9;
                else                 state_next = S_FX1;
            end
            S_FX2:   state_next = stat.fix_b ? S_U9 : S_FX1;
            S_U9:    state_next = S_U10;
            S_U10:   state_next = S_U0;
            S_UROOT: state_next = S_FIN;
            S_DREAD: state_next = S_DCHK;
            S_DCHK:
            begin
                if (stat.dc_internal)  state_next = S_IDLE;
                else if (stat.dc_stop) state_next = S_FIN;
                else                   state_next = S_U0;
            end
            S_FIN:   if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_CLR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_clr_only_from_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLR) |=> (state_reg != S_CLR))
        else $error("clearing pass re-entered");

    a_fin_leaves_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("result not released");

    a_fix_then_parent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_U7) |=> (state_reg == S_FX1))
        else $error("swap not followed by fix-up");

endmodule

>>> hdl/ahc_dpath.sv
// Datapath: node table RAMs, symbol-to-leaf RAM, walk and update registers, result register.
// Depends on ahc_pkg, ahc_if and ahc_ram.
`timescale 1ns / 1ps
module ahc_dpath
    import ahc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    output stat_t        stat,
    ahc_req_if.sink      req,
    ahc_rsp_if.source    rsp
);

    logic [SLOT_W-1:0]      raddr, waddr;
    logic                   we_p, we_f, we_w, we_s;
    logic [SLOT_W-1:0]      wd_p, wd_f, rd_p, rd_f;
    logic [WEIGHT_BITS-1:0] wd_w, rd_w;
    logic [SYM_W-1:0]       wd_s, rd_s;

    logic                   l_we;
    logic [SYM_W-1:0]       l_waddr;
    logic [SLOT_W-1:0]      l_wd, l_rd;

    logic [1:0]             func_reg;
    logic [SYM_W-1:0]       sym_reg;
    logic                   bit_reg, fresh_reg, fsel_reg;
    logic [SLOT_W-1:0]      leaf_reg, dpos_reg, n_reg, lm_reg, pn_reg, fcn_reg, fcl_reg;
    logic [SLOT_W-1:0]      s_reg, p_reg, c_reg, clr_reg;
    logic [SYM_W-1:0]       symn_reg, syml_reg;
    logic [LC_W-1:0]        lc_reg;
    logic [WEIGHT_BITS-1:0] root_w_reg, wn_reg;
    logic [63:0]            code_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [SYM_COUNT-1:0]   lvalid_reg;

    logic [1:0]             res_st_reg;
    logic [63:0]            res_code_reg;
    logic [LEN_W-1:0]       res_len_reg;
    logic                   res_new_reg;
    logic [SYM_W-1:0]       res_sym_reg;

    logic                   out_valid_reg;
    logic [1:0]             out_st_reg;
    logic [63:0]            out_code_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic                   out_new_reg;
    logic [SYM_W-1:0]       out_sym_reg;

    logic [SLOT_W-1:0]      nyt, l_slot, r_slot, fx_slot, fx_fc;
    logic [SYM_W-1:0]       fx_sym;
    logic                   root_full, lc_full, sym_ok, enc_err, lit_ok, fire;

    ahc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_par (
        .clk(clk), .we(we_p), .waddr(waddr), .wdata(wd_p), .raddr(raddr), .rdata(rd_p));
    ahc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_fc (
        .clk(clk), .we(we_f), .waddr(waddr), .wdata(wd_f), .raddr(raddr), .rdata(rd_f));
    ahc_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(SLOTS)) u_wt (
        .clk(clk), .we(we_w), .waddr(waddr), .wdata(wd_w), .raddr(raddr), .rdata(rd_w));
    ahc_ram #(.WIDTH(SYM_W), .DEPTH(SLOTS)) u_sym (
        .clk(clk), .we(we_s), .waddr(waddr), .wdata(wd_s), .raddr(raddr), .rdata(rd_s));
    ahc_ram #(.WIDTH(SLOT_W), .DEPTH(SYM_COUNT)) u_leaf (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wd), .raddr(req.symbol), .rdata(l_rd));

    assign nyt       = {lc_reg, 1'b0};
    assign l_slot    = nyt + SLOT_W'(1);
    assign r_slot    = nyt + SLOT_W'(2);
    assign root_full = (root_w_reg == '1);
    assign lc_full   = (lc_reg >= LC_W'(ALPHABET));
    assign sym_ok    = ({1'b0, sym_reg} < LC_W'(ALPHABET));
    assign enc_err   = !sym_ok || (fresh_reg && lc_full) || root_full;
    assign lit_ok    = (dpos_reg == nyt) && sym_ok && fresh_reg && !lc_full;
    assign fire      = req.valid && req.ready;
    assign fx_slot   = fsel_reg ? lm_reg : n_reg;
    assign fx_fc     = fsel_reg ? fcn_reg : fcl_reg;
    assign fx_sym    = fsel_reg ? symn_reg : syml_reg;

    assign req.ready      = (cmd.op == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_st_reg;
    assign rsp.code_bits  = out_code_reg;
    assign rsp.code_len   = out_len_reg;
    assign rsp.is_new     = out_new_reg;
    assign rsp.out_symbol = out_sym_reg;

    always_comb
    begin
        stat             = '0;
        stat.clr_done    = (clr_reg == SLOT_W'(SLOTS - 1));
        stat.fire        = fire;
        stat.fresh       = fresh_reg;
        stat.wa_done     = (s_reg == '0);
        stat.wa_err      = (len_reg >= LEN_W'(MAX_CODE_BITS));
        stat.n_zero      = (n_reg == '0);
        stat.lm_zero     = (lm_reg == '0);
        stat.w_eq        = (rd_w == wn_reg);
        stat.lm_eq_n     = (lm_reg == n_reg);
        stat.fix_int     = (fx_fc != '0);
        stat.fix_b       = fsel_reg;
        stat.dc_internal = (rd_f != '0);
        stat.dc_stop     = (c_reg == nyt) || root_full;
        stat.out_free    = !out_valid_reg || rsp.ready;
        case (func_reg)
            FN_ENC:
            begin
                stat.d_res  = enc_err;
                stat.d_walk = !enc_err;
            end
            FN_DEC:
            begin
                stat.d_dread = (rd_f != '0);
                stat.d_res   = (rd_f == '0);
            end
            FN_LIT:
            begin
                stat.d_add = lit_ok && !root_full;
                stat.d_res = !(lit_ok && !root_full);
            end
            default: stat.d_none = 1'b1;
        endcase
    end

    // node table read address and write port
    always_comb
    begin
        raddr   = '0;
        waddr   = '0;
        {we_p, we_f, we_w, we_s} = '0;
        wd_p    = '0;
        wd_f    = '0;
        wd_w    = '0;
        wd_s    = '0;
        l_we    = 1'b0;
        l_waddr = sym_reg;
        l_wd    = l_slot;
        unique case (cmd.op)
            S_CLR:
            begin
                waddr = clr_reg;
                {we_p, we_f, we_w, we_s} = '1;
            end
            S_IDLE:  raddr = dpos_reg;
            S_WA:    raddr = s_reg;
            S_WB:    raddr = rd_p;
            S_ADD1:
            begin
                waddr = nyt;
                we_f  = 1'b1;
                wd_f  = l_slot;
                l_we  = 1'b1;
            end
            S_ADD2:
            begin
                waddr = l_slot;
                {we_p, we_f, we_w, we_s} = '1;
                wd_p  = nyt;
                wd_s  = sym_reg;
            end
            S_ADD3:
            begin
                waddr = r_slot;
                {we_p, we_f, we_w, we_s} = '1;
                wd_p  = nyt;
            end
            S_U0:    raddr = n_reg;
            S_U2:    raddr = lm_reg - SLOT_W'(1);
            S_U5:
            begin
                raddr = lm_reg;
                if (lm_reg == n_reg)
                begin
                    waddr = n_reg;
                    we_w  = 1'b1;
                    wd_w  = wn_reg + WEIGHT_BITS'(1);
                end
            end
            S_U6:
            begin
                waddr = n_reg;
                {we_f, we_w, we_s} = '1;
                wd_f  = rd_f;
                wd_w  = rd_w;
                wd_s  = rd_s;
            end
            S_U7:
            begin
                waddr = lm_reg;
                {we_f, we_w, we_s} = '1;
                wd_f  = fcn_reg;
                wd_w  = wn_reg + WEIGHT_BITS'(1);
                wd_s  = symn_reg;
            end
            S_FX1:
            begin
                waddr = fx_fc;
                wd_p  = fx_slot;
                we_p  = (fx_fc != '0);
                l_waddr = fx_sym;
                l_wd  = fx_slot;
                l_we  = (fx_fc == '0) && (fx_slot != nyt);
            end
            S_FX2:
            begin
                waddr = fx_fc + SLOT_W'(1);
                wd_p  = fx_slot;
                we_p  = 1'b1;
            end
            S_U9:    raddr = lm_reg;
            S_UROOT:
            begin
                we_w  = 1'b1;
                wd_w  = root_w_reg + WEIGHT_BITS'(1);
            end
            S_DREAD: raddr = c_reg;
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg <= '0; sym_reg <= '0; bit_reg <= 1'b0; fresh_reg <= 1'b0;
            fsel_reg <= 1'b0; leaf_reg <= '0; dpos_reg <= '0; n_reg <= '0;
            lm_reg <= '0; pn_reg <= '0; fcn_reg <= '0; fcl_reg <= '0;
            s_reg <= '0; p_reg <= '0; c_reg <= '0; clr_reg <= '0;
            symn_reg <= '0; syml_reg <= '0; lc_reg <= '0;
            root_w_reg <= '0; wn_reg <= '0; code_reg <= '0; len_reg <= '0;
            lvalid_reg <= '0;
            res_st_reg <= '0; res_code_reg <= '0; res_len_reg <= '0;
            res_new_reg <= 1'b0; res_sym_reg <= '0;
            out_valid_reg <= 1'b0; out_st_reg <= '0; out_code_reg <= '0;
            out_len_reg <= '0; out_new_reg <= 1'b0; out_sym_reg <= '0;
        end
        else
        begin
            if (we_w && waddr == '0)
            begin
                root_w_reg <= wd_w;
            end
            if (l_we)
            begin
                lvalid_reg[l_waddr] <= 1'b1;
            end
            // load a finished item, or drop the one just taken
            if (cmd.op == S_FIN && stat.out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                S_CLR: clr_reg <= clr_reg + SLOT_W'(1);
                S_IDLE:
                begin
                    if (fire)
                    begin
                        func_reg  <= req.func;
                        sym_reg   <= req.symbol;
                        bit_reg   <= req.bit_req;
                        fresh_reg <= !lvalid_reg[req.symbol];
                    end
                end
                S_DISP:
                begin
                    leaf_reg     <= l_rd;
                    res_st_reg   <= RES_ERR;
                    res_code_reg <= '0;
                    res_len_reg  <= '0;
                    res_new_reg  <= 1'b0;
                    res_sym_reg  <= '0;
                    case (func_reg)
                        FN_ENC:
                        begin
                            dpos_reg <= '0;
                            s_reg    <= fresh_reg ? nyt : l_rd;
                            code_reg <= '0;
                            len_reg  <= '0;
                        end
                        FN_DEC:
                        begin
                            c_reg <= rd_f + SLOT_W'(bit_reg);
                            if (rd_f == '0)
                            begin
                                if (dpos_reg == nyt)
                                begin
                                    res_st_reg <= RES_LIT;
                                end
                                else
                                begin
                                    dpos_reg <= '0;
                                end
                            end
                        end
                        FN_LIT:
                        begin
                            if (lit_ok)
                            begin
                                // dispatch already knows the literal is accepted or the root is full
                                dpos_reg <= '0;
                                if (!root_full)
                                begin
                                    res_st_reg  <= RES_SYM;
                                    res_new_reg <= 1'b1;
                                    res_sym_reg <= sym_reg;
                                end
                            end
                        end
                        default: res_st_reg <= RES_ERR;
                    endcase
                end
                S_WA:
                begin
                    if (s_reg == '0)
                    begin
                        n_reg        <= leaf_reg;
                        res_st_reg   <= RES_CODE;
                        res_code_reg <= code_reg;
                        res_len_reg  <= len_reg;
                        res_new_reg  <= fresh_reg;
                        res_sym_reg  <= sym_reg;
                    end
                end
                S_WB: p_reg <= rd_p;
                S_WC:
                begin
                    // right child when the slot sits just after its sibling
                    if (s_reg == rd_f + SLOT_W'(1))
                    begin
                        code_reg[len_reg[CIDX_W-1:0]] <= 1'b1;
                    end
                    len_reg <= len_reg + LEN_W'(1);
                    s_reg   <= p_reg;
                end
                S_ADD3:
                begin
                    lc_reg <= lc_reg + LC_W'(1);
                    n_reg  <= l_slot;
                end
                S_U1:
                begin
                    wn_reg   <= rd_w;
                    fcn_reg  <= rd_f;
                    symn_reg <= rd_s;
                    pn_reg   <= rd_p;
                    lm_reg   <= n_reg;
                end
                S_U3:
                begin
                    if (rd_w == wn_reg)
                    begin
                        lm_reg <= lm_reg - SLOT_W'(1);
                    end
                end
                S_U4:
                begin
                    // never swap a node with its own parent
                    if (pn_reg == lm_reg)
                    begin
                        lm_reg <= lm_reg + SLOT_W'(1);
                    end
                end
                S_U6:
                begin
                    fcl_reg  <= rd_f;
                    syml_reg <= rd_s;
                end
                S_U7:  fsel_reg <= 1'b0;
                S_FX1:
                begin
                    if (fx_fc == '0)
                    begin
                        fsel_reg <= 1'b1;
                    end
                end
                S_FX2: fsel_reg <= 1'b1;
                S_U10: n_reg <= rd_p;
                S_DCHK:
                begin
                    if (rd_f != '0)
                    begin
                        dpos_reg <= c_reg;
                    end
                    else if (c_reg == nyt)
                    begin
                        dpos_reg   <= c_reg;
                        res_st_reg <= RES_LIT;
                    end
                    else
                    begin
                        dpos_reg <= '0;
                        n_reg    <= c_reg;
                        if (!root_full)
                        begin
                            res_st_reg  <= RES_SYM;
                            res_sym_reg <= rd_s;
                        end
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_st_reg    <= res_st_reg;
                        out_code_reg  <= res_code_reg;
                        out_len_reg   <= res_len_reg;
                        out_new_reg   <= res_new_reg;
                        out_sym_reg   <= res_sym_reg;
                    end
                end
                default: clr_reg <= clr_reg;
            endcase
        end
    end

    a_lc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= LC_W'(ALPHABET))
        else $error("leaf count beyond alphabet");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == S_ADD3) |=> (lc_reg == $past(lc_reg) + LC_W'(1)))
        else $error("leaf count not advanced by split");

    a_dpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        dpos_reg < SLOT_W'(SLOTS))
        else $error("decode position out of table");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == S_FIN && stat.out_free) |=> rsp.valid)
        else $error("result lost at output register");

endmodule

>>> hdl/adaptive_huffman_codec_core.sv
// Top level of the adaptive Huffman (FGK) codec: controller plus datapath.
// Depends on ahc_pkg, ahc_if, ahc_ctrl and ahc_dpath.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   func, symbol, bit_req
//   rsp      out  valid/ready   status, code_bits, code_len, is_new, out_symbol
//
// After reset a clearing pass zeroes the node table; req.ready stays low.
// One item at a time: encode walks up from the leaf through WA, WB and WC per code bit, then
// per tree level searches for the block leader by weight compares, swaps with it unless the
// node already leads its block, and fixes the parent link of each internal node moved. A
// decode bit on an internal node runs DREAD then DCHK; the node RAM port sets the pace.
// A finished result waits in the output register; a stalled rsp holds only the last state.
`timescale 1ns / 1ps
module adaptive_huffman_codec_core
    import ahc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ahc_req_if.sink   req,
    ahc_rsp_if.source rsp
);

    cmd_t  cmd;
    stat_t stat;

    ahc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    ahc_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
